// ----- rtl/fifo_free_list_id_allocator_assert.svh -----
// Assertion macros for the checker file.
`ifndef FIFO_FREE_LIST_ID_ALLOCATOR_ASSERT_SVH
`define FIFO_FREE_LIST_ID_ALLOCATOR_ASSERT_SVH

// Clocked property, ignored while reset is asserted.
`define FFLA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that must never hold.
`define FFLA_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/ffla_pkg.sv -----
`timescale 1ns / 1ps

package ffla_pkg;

    // Default pool geometry
    localparam int POOL_SIZE_DEF = 1024;
    localparam int CHUNK_DEF     = 64;

    // Capacity limit register
    localparam int                 CFG_W           = 11;
    localparam logic [CFG_W-1:0]   MAX_ENTRIES_RST = 11'd1024;

    // Result status codes
    localparam int              ST_W         = 2;
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_ID    = 2'd2;

    // Request kinds
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // transaction taken this cycle, update state
        logic link_load;  // link read data is valid, load new head
    } ffla_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_link;  // current request pops a list with more than one entry
    } ffla_sts_t;

endpackage

// ----- rtl/ffla_ram.sv -----
`timescale 1ns / 1ps

module ffla_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ffla_ctrl.sv -----
`timescale 1ns / 1ps

module ffla_ctrl
    import ffla_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  ffla_sts_t sts,
    output ffla_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LINK = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;

    // Take a request when idle and the result register is free or draining
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign cmd.accept    = accept;
    assign cmd.link_load = (state_reg == S_LINK);
    assign m_tvalid      = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && sts.need_link)
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/ffla_datapath.sv -----
`timescale 1ns / 1ps

module ffla_datapath
    import ffla_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF,
    parameter int CHUNK     = CHUNK_DEF,
    parameter int ID_W      = $clog2(POOL_SIZE),
    parameter int CNT_W     = $clog2(POOL_SIZE + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             action,
    input  logic [ID_W-1:0]  release_id,
    input  ffla_cmd_t        cmd,
    output ffla_sts_t        sts,
    output logic [ID_W-1:0]  entry_id,
    output logic [ST_W-1:0]  status
);

    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CHK_W   = $clog2(CHUNK + 1);
    localparam int SUM_W   = ((CNT_W > CHK_W) ? CNT_W : CHK_W) + 1;

    logic [CFG_W-1:0] max_reg;
    logic [CNT_W-1:0] hw_reg,  hw_next;
    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0] fc_reg,  fc_next;
    logic [ID_W-1:0]  head_reg, head_next;
    logic [ID_W-1:0]  tail_reg, tail_next;
    logic [ID_W-1:0]  out_id_reg, out_id_next;
    logic [ST_W-1:0]  out_st_reg, out_st_next;

    logic             fc_zero;
    logic             at_cap;
    logic             cap_full;
    logic [SUM_W-1:0] cap_sum;
    logic [CNT_W-1:0] cap_grown;
    logic [CNT_W-1:0] rid_ext;
    logic             rel_bad;
    logic             need_link;
    logic             ram_we;
    logic             ram_re;
    logic [ID_W-1:0]  link_rdata;

    // Pool bookkeeping terms
    assign fc_zero  = (fc_reg == '0);
    assign at_cap   = (hw_reg >= cap_reg);
    assign cap_full = (CMP_W'(cap_reg) >= CMP_W'(max_reg)) ||
                      (cap_reg >= CNT_W'(POOL_SIZE));
    assign cap_sum   = SUM_W'(cap_reg) + SUM_W'(CHUNK);
    assign cap_grown = (cap_sum > SUM_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE)
                                                     : cap_sum[CNT_W-1:0];

    // Release checks
    assign rid_ext = CNT_W'(release_id);
    assign rel_bad = (rid_ext >= hw_reg) || (rid_ext >= CNT_W'(POOL_SIZE)) ||
                     (fc_reg >= hw_reg);

    // Pop that leaves a nonempty list needs the head's link
    assign need_link     = (action == ACT_ALLOC) && !fc_zero && (fc_reg != CNT_W'(1));
    assign sts.need_link = need_link;

    // Link store access
    assign ram_we = cmd.accept && (action == ACT_RELEASE) && !rel_bad && !fc_zero;
    assign ram_re = cmd.accept && need_link;

    ffla_ram #(
        .WIDTH (ID_W),
        .DEPTH (POOL_SIZE)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (release_id),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    // State and result update
    always_comb
    begin
        hw_next     = hw_reg;
        cap_next    = cap_reg;
        fc_next     = fc_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        out_id_next = out_id_reg;
        out_st_next = out_st_reg;

        if (cmd.link_load)
        begin
            head_next = link_rdata;
        end

        if (cmd.accept)
        begin
            out_id_next = '0;
            out_st_next = ST_OK;
            if (action == ACT_ALLOC)
            begin
                if (fc_zero)
                begin
                    if (at_cap && cap_full)
                    begin
                        out_st_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        if (at_cap)
                        begin
                            cap_next = cap_grown;
                        end
                        out_id_next = hw_reg[ID_W-1:0];
                        hw_next     = hw_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    out_id_next = head_reg;
                    fc_next     = fc_reg - CNT_W'(1);
                    if (fc_reg == CNT_W'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                end
            end
            else
            begin
                if (rel_bad)
                begin
                    out_st_next = ST_BAD_ID;
                end
                else
                begin
                    if (fc_zero)
                    begin
                        head_next = release_id;
                    end
                    tail_next = release_id;
                    fc_next   = fc_reg + CNT_W'(1);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= MAX_ENTRIES_RST;
            hw_reg   <= '0;
            cap_reg  <= '0;
            fc_reg   <= '0;
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
            hw_reg   <= hw_next;
            cap_reg  <= cap_next;
            fc_reg   <= fc_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_id_reg <= out_id_next;
        out_st_reg <= out_st_next;
    end

    assign entry_id = out_id_reg;
    assign status   = out_st_reg;

endmodule

// ----- rtl/fifo_free_list_id_allocator.sv -----
`timescale 1ns / 1ps
// Identifier allocator with a FIFO free list and a growing high-water mark.
// Requests arrive on the s_ stream: tuser selects allocate (0) or release (1),
// tdata carries the identifier to release. Each request gives exactly one
// result on the m_ stream: tdata holds the granted identifier (zero when
// nothing is granted), tuser the status (ok, pool exhausted, bad identifier).
// The cfg channel writes the capacity limit max_entries; it is always ready.
// The user must see that it is written only while no request is in flight; the block does not enforce it.
// Latency: the result is registered at the edge that accepts the request and
// is shown in the next cycle. Throughput is one request per cycle, except for
// an allocate that pops a free list holding more than one entry: the next request
// waits while the new list head comes from the link memory's registered read.
// A stalled receiver holds the result register; a new request is taken only
// in a cycle where that register is empty or being drained.
// Reset empties the free list, clears the high-water mark and capacity and
// sets max_entries to 1024. The link memory is not cleared: an entry is read
// only after a release has written it.
module fifo_free_list_id_allocator
    import ffla_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF,
    parameter int CHUNK     = CHUNK_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             cfg_valid,
    output logic                                             cfg_ready,
    input  logic [CFG_W-1:0]                                 cfg_data,
    input  logic                                             s_tvalid,
    output logic                                             s_tready,
    input  logic [((($clog2(POOL_SIZE)) + 7) / 8) * 8 - 1:0] s_tdata,  // release_id
    input  logic                                             s_tuser,  // action
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    output logic [((($clog2(POOL_SIZE)) + 7) / 8) * 8 - 1:0] m_tdata,  // entry_id
    output logic [ST_W-1:0]                                  m_tuser   // status
);

    localparam int ID_W   = $clog2(POOL_SIZE);
    localparam int CNT_W  = $clog2(POOL_SIZE + 1);
    localparam int DATA_W = ((ID_W + 7) / 8) * 8;

    ffla_cmd_t       cmd;
    ffla_sts_t       sts;
    logic [ID_W-1:0] entry_id;

    assign cfg_ready = 1'b1;

    ffla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffla_datapath #(
        .POOL_SIZE (POOL_SIZE),
        .CHUNK     (CHUNK),
        .ID_W      (ID_W),
        .CNT_W     (CNT_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .action     (s_tuser),
        .release_id (s_tdata[ID_W-1:0]),
        .cmd        (cmd),
        .sts        (sts),
        .entry_id   (entry_id),
        .status     (m_tuser)
    );

    assign m_tdata = DATA_W'(entry_id);

endmodule

// ----- rtl/ffla_checker.sv -----
`timescale 1ns / 1ps
`include "fifo_free_list_id_allocator_assert.svh"

module ffla_checker
    import ffla_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input logic                                             clk,
    input logic                                             rst_n,
    input logic                                             s_tvalid,
    input logic                                             s_tready,
    input logic                                             m_tvalid,
    input logic                                             m_tready,
    input logic [((($clog2(POOL_SIZE)) + 7) / 8) * 8 - 1:0] m_tdata,
    input logic [ST_W-1:0]                                  m_tuser
);

    logic                           out_stall;
    logic                           out_fail;
    logic [ST_W+$bits(m_tdata)-1:0] out_word;

    // Result side terms
    assign out_stall = m_tvalid && !m_tready;
    assign out_fail  = (m_tuser == ST_EXHAUSTED) || (m_tuser == ST_BAD_ID);
    assign out_word  = {m_tuser, m_tdata};

    // A stalled result holds
    `FFLA_ASSERT(a_hold, clk, rst_n, out_stall |=> m_tvalid && $stable(out_word), "result not held")

    // Every accepted request shows a result next cycle
    `FFLA_ASSERT(a_result_follows, clk, rst_n, s_tvalid && s_tready |=> m_tvalid, "no result")

    // No request accepted while the result register is blocked
    `FFLA_NEVER(a_no_overrun, clk, rst_n, out_stall && s_tready, "taken over held result")

    // Failed results carry no identifier
    `FFLA_ASSERT(a_zero_id, clk, rst_n, m_tvalid && out_fail |-> m_tdata == '0, "id on failed result")

endmodule

bind fifo_free_list_id_allocator ffla_checker #(.POOL_SIZE(POOL_SIZE)) u_ffla_checker (.*);
